/* hw/rtl/clq_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clq_pkg
// Shared constants, types and character helpers of the command line queue.
// ---------------------------------------------------------------------------
package clq_pkg;

  localparam int LINE_BYTES  = 64;
  localparam int LINE_W      = $clog2(LINE_BYTES);
  localparam int QUEUE_SLOTS = 8;
  localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
  localparam int ADDR_W      = SLOT_W + LINE_W;
  localparam int IDLE_W      = 17;
  localparam int TIMEOUT_W   = 16;
  localparam int SRC_W       = 2;
  localparam int CNT_W       = 32;
  localparam int WORD_MAX    = 6;
  localparam int WLEN_W      = 3;

  localparam logic [LINE_W-1:0]    MAX_LEN       = LINE_W'(LINE_BYTES - 1);
  localparam logic [IDLE_W-1:0]    IDLE_MAX      = {IDLE_W{1'b1}};
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd150;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_POP  = 2'd2;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_SOURCE  = 1'b1;

  localparam logic [7:0] CHAR_CR   = 8'h0d;
  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_TAB  = 8'h09;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  typedef struct packed {
    logic byte_en;
    logic tick_en;
    logic pop_start;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic pop_short;
    logic last;
  } dp_stat_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SP) || (c == CHAR_TAB);
  endfunction

  function automatic logic word_match(input logic [8*WORD_MAX-1:0] w,
                                      input logic [WLEN_W-1:0] n);
    return (n == 3'd4 && w[31:0] == "stop")  ||
           (n == 3'd1 && w[7:0]  == "s")     ||
           (n == 3'd5 && w[39:0] == "estop") ||
           (n == 3'd4 && w[31:0] == "safe")  ||
           (n == 3'd6 && w[47:0] == "alloff") ||
           (n == 3'd1 && w[7:0]  == "x")     ||
           (n == 3'd5 && w[39:0] == "brake");
  endfunction

  function automatic logic rp_match(input logic [8*WORD_MAX-1:0] w,
                                    input logic [WLEN_W-1:0] n);
    return (n == 3'd3) && (w[23:0] == "rpm" || w[23:0] == "pwm");
  endfunction

endpackage

/* hw/rtl/clq_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clq_ctrl
// Controller: decodes input transactions and sequences pop output.
// ---------------------------------------------------------------------------
module clq_ctrl import clq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic [1:0] s_tuser,
  output logic     m_tvalid,
  input  logic     m_tready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state, state_next;
  logic   take;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT);
  assign take     = s_tvalid && s_tready;

  always_comb begin
    cmd.byte_en   = take && (s_tuser == CMD_BYTE);
    cmd.tick_en   = take && (s_tuser == CMD_TICK);
    cmd.pop_start = take && (s_tuser == CMD_POP);
    cmd.advance   = (state == ST_EMIT) && m_tready && !stat.last;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.pop_start) begin
          state_next = stat.pop_short ? ST_EMIT : ST_READ;
        end
      end
      ST_READ: state_next = ST_EMIT;
      ST_EMIT: begin
        if (m_tready) begin
          state_next = stat.last ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/clq_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clq_dp
// Datapath: line assembly, emergency matcher, slot memory, ring and counters.
// ---------------------------------------------------------------------------
module clq_dp import clq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           pop_limit,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [TIMEOUT_W-1:0] cfg_data,
  output logic                 pop_ok,
  output logic                 char_valid,
  output logic [7:0]           line_char,
  output logic                 last,
  output logic [SRC_W-1:0]     line_source,
  output logic [CNT_W-1:0]     drop_total,
  output logic [CNT_W-1:0]     preempt_total
);

  typedef enum logic [5:0] {
    M_LEAD  = 6'b000001,
    M_WORD  = 6'b000010,
    M_TRAIL = 6'b000100,
    M_RBLK  = 6'b001000,
    M_RZERO = 6'b010000,
    M_FAIL  = 6'b100000
  } match_t;

  logic [7:0]           mem [LINE_BYTES*QUEUE_SLOTS];
  logic [7:0]           rdata;
  logic [LINE_W-1:0]    slot_len [QUEUE_SLOTS];
  logic [SRC_W-1:0]     slot_src [QUEUE_SLOTS];

  logic [SLOT_W-1:0]    write_slot, read_slot, pop_slot;
  logic [LINE_W-1:0]    partial_length, pop_idx, pop_count;
  logic [IDLE_W-1:0]    idle_count, idle_inc;
  logic [TIMEOUT_W-1:0] timeout;
  logic [SRC_W-1:0]     source;
  logic [CNT_W-1:0]     drop_counter, preempt_counter;
  logic                 out_ok, out_cv, out_last;
  logic [SRC_W-1:0]     out_src;

  match_t                phase, phase_next, cur_phase;
  logic [8*WORD_MAX-1:0] wbuf, wbuf_next;
  logic [WLEN_W-1:0]     wlen, wlen_next;

  logic [7:0]        lc;
  logic              crlf, blank, store, emergency, commit, full, accept_line, empty;
  logic [SLOT_W-1:0] wnext;
  logic [LINE_W-1:0] head_len, pop_n;
  logic [7:0]        lim_m1;

  assign crlf      = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
  assign blank     = is_blank(rx_byte);
  assign lc        = to_lower(rx_byte);
  assign store     = cmd.byte_en && !crlf && (partial_length != MAX_LEN);
  assign cur_phase = (partial_length == '0) ? M_LEAD : phase;
  assign emergency = (phase == M_WORD && word_match(wbuf, wlen)) ||
                     (phase == M_TRAIL) || (phase == M_RZERO);
  assign idle_inc  = (idle_count == IDLE_MAX) ? idle_count : idle_count + 1'b1;
  assign commit    = (partial_length != '0) &&
                     ((cmd.byte_en && crlf) ||
                      (cmd.tick_en && idle_inc > {1'b0, timeout}));
  assign wnext       = write_slot + 1'b1;
  assign full        = (wnext == read_slot);
  assign accept_line = commit && (!full || emergency);
  assign empty       = (read_slot == write_slot);
  assign head_len    = slot_len[read_slot];
  assign lim_m1      = pop_limit - 8'd1;
  assign pop_n       = ({2'b00, head_len} >= pop_limit) ? lim_m1[LINE_W-1:0] : head_len;

  assign stat.pop_short = empty || (pop_limit == 8'd0) || (pop_n == '0);
  assign stat.last      = out_last;

  always_comb begin
    phase_next = phase;
    wbuf_next  = wbuf;
    wlen_next  = wlen;
    if (store) begin
      unique case (cur_phase)
        M_LEAD: begin
          if (!blank) begin
            phase_next = M_WORD;
            wbuf_next  = {{8*(WORD_MAX-1){1'b0}}, lc};
            wlen_next  = 3'd1;
          end else begin
            phase_next = M_LEAD;
          end
        end
        M_WORD: begin
          if (blank) begin
            if (rp_match(wbuf, wlen)) begin
              phase_next = M_RBLK;
            end else if (word_match(wbuf, wlen)) begin
              phase_next = M_TRAIL;
            end else begin
              phase_next = M_FAIL;
            end
          end else if (wlen == WLEN_W'(WORD_MAX)) begin
            phase_next = M_FAIL;
          end else begin
            wbuf_next = {wbuf[8*(WORD_MAX-1)-1:0], lc};
            wlen_next = wlen + 1'b1;
          end
        end
        M_TRAIL: phase_next = blank ? M_TRAIL : M_FAIL;
        M_RBLK: begin
          if (blank) begin
            phase_next = M_RBLK;
          end else begin
            phase_next = (rx_byte == CHAR_ZERO) ? M_RZERO : M_FAIL;
          end
        end
        M_RZERO: phase_next = blank ? M_RZERO : M_FAIL;
        M_FAIL:  phase_next = M_FAIL;
        default: phase_next = M_FAIL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[{pop_slot, pop_idx}];
    if (store) begin
      mem[{write_slot, partial_length}] <= rx_byte;
    end
    if (accept_line) begin
      slot_len[write_slot] <= partial_length;
      slot_src[write_slot] <= source;
    end
    wbuf <= wbuf_next;
    wlen <= wlen_next;
    if (cmd.pop_start) begin
      pop_slot  <= read_slot;
      pop_idx   <= '0;
      pop_count <= pop_n;
      if (empty || pop_limit == 8'd0) begin
        out_ok   <= 1'b0;
        out_cv   <= 1'b0;
        out_last <= 1'b1;
        out_src  <= '0;
      end else begin
        out_ok   <= 1'b1;
        out_cv   <= (pop_n != '0);
        out_last <= (pop_n <= LINE_W'(1));
        out_src  <= slot_src[read_slot];
      end
    end else if (cmd.advance) begin
      pop_idx  <= pop_idx + 1'b1;
      out_last <= ((LINE_W+1)'(pop_idx) + 2'd2 == {1'b0, pop_count});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot      <= '0;
      read_slot       <= '0;
      partial_length  <= '0;
      idle_count      <= '0;
      timeout         <= TIMEOUT_RESET;
      source          <= '0;
      drop_counter    <= '0;
      preempt_counter <= '0;
      phase           <= M_LEAD;
    end else begin
      phase <= phase_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TIMEOUT: timeout <= cfg_data;
          CFG_SOURCE:  source  <= cfg_data[SRC_W-1:0];
          default:     timeout <= timeout;
        endcase
      end
      if (cmd.byte_en) begin
        idle_count <= '0;
        if (crlf || partial_length == MAX_LEN) begin
          partial_length <= '0;
        end else begin
          partial_length <= partial_length + 1'b1;
        end
      end
      if (cmd.tick_en) begin
        idle_count <= idle_inc;
        if (commit) begin
          partial_length <= '0;
        end
      end
      if (commit) begin
        if (!full) begin
          write_slot <= wnext;
        end else if (emergency) begin
          write_slot      <= wnext;
          read_slot       <= read_slot + 1'b1;
          preempt_counter <= preempt_counter + 1'b1;
        end else begin
          drop_counter <= drop_counter + 1'b1;
        end
      end
      if (cmd.pop_start && !empty && pop_limit != 8'd0) begin
        read_slot <= read_slot + 1'b1;
      end
    end
  end

  assign pop_ok        = out_ok;
  assign char_valid    = out_cv;
  assign line_char     = out_cv ? rdata : 8'd0;
  assign last          = out_last;
  assign line_source   = out_src;
  assign drop_total    = drop_counter;
  assign preempt_total = preempt_counter;

`ifndef SYNTHESIS
  a_ring_not_empty: assert property (@(posedge clk) disable iff (rst)
    accept_line |=> (write_slot != read_slot))
    else $error("ring reads empty after a line was queued");

  a_drop_on_commit: assert property (@(posedge clk) disable iff (rst)
    !$stable(drop_counter) |-> $past(commit))
    else $error("drop counter moved without a commit");

  a_idx_in_line: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |-> ((LINE_W+1)'(pop_idx) + 1'b1 < {1'b0, pop_count}))
    else $error("pop advanced past the line length");
`endif

endmodule

/* hw/rtl/command_line_queue_with_estop_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// command_line_queue_with_estop_core
// Command line assembler and queue with emergency-stop preemption.
// ---------------------------------------------------------------------------
// A byte or tick transaction leaves the block idle, so it stays ready for the
// next input. A pop is accepted in the idle state. A pop that yields a single
// result without a character (empty queue, zero limit or nothing left after
// truncation) shows it on the next cycle. Each character of a pop passes through
// the READ and EMIT states (slot memory read, then the output register), and a
// stall on the output side holds it in EMIT. The next input is taken once the
// last result of a pop has been accepted. There is no clearing pass after reset.
module command_line_queue_with_estop_core import clq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // rx_byte, pop_limit
  input  logic [1:0]           s_tuser,   // command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [79:0]          m_tdata,   // line_char, line_source, drop_total, preempt_total
  output logic [1:0]           m_tuser,   // pop_ok, char_valid
  output logic                 m_tlast,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [TIMEOUT_W-1:0] cfg_data
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic             pop_ok, char_valid, last;
  logic [7:0]       line_char;
  logic [SRC_W-1:0] line_source;
  logic [CNT_W-1:0] drop_total, preempt_total;

  clq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  clq_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .rx_byte       (s_tdata[7:0]),
    .pop_limit     (s_tdata[15:8]),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pop_ok        (pop_ok),
    .char_valid    (char_valid),
    .line_char     (line_char),
    .last          (last),
    .line_source   (line_source),
    .drop_total    (drop_total),
    .preempt_total (preempt_total)
  );

  assign m_tdata = {6'b000000, preempt_total, drop_total, line_source, line_char};
  assign m_tuser = {char_valid, pop_ok};
  assign m_tlast = last;

endmodule
